### hw/rtl/rme_pkg.sv
// Shared types, constants and lookup functions for the rotation matrix to
// Euler angle converter. Used by every module under hw/rtl; depends on nothing.
package rme_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int N_IN            = 7;
    localparam int ANGLE_W         = 16;
    localparam int THR_W           = 15;
    localparam int N_LANES         = 3;

    localparam int IN_TDATA_W      = ((N_IN * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W     = N_LANES * ANGLE_W;

    // Square root datapath: one result bit per cell.
    localparam int SUM_W           = 2 * SAMPLE_WIDTH;
    localparam int SQRT_STAGES     = SAMPLE_WIDTH;
    localparam int SQ_IDX_W        = $clog2(SQRT_STAGES);
    localparam int SY_W            = SAMPLE_WIDTH;

    // CORDIC datapath: operands carry 16 guard bits and headroom for the gain.
    localparam int OPND_W          = SAMPLE_WIDTH + 1;
    localparam int GUARD_SHIFT     = 16;
    localparam int CD_W            = OPND_W + GUARD_SHIFT + 3;
    localparam int Z_W             = 20;
    localparam int CD_IDX_W        = $clog2(CORDIC_STAGES);
    localparam int ATAN_IDX_W      = 5;

    localparam logic [THR_W-1:0]         THR_RESET    = THR_W'(1);
    localparam logic signed [Z_W-1:0]    HALF_PI_Z    = Z_W'(102944);
    localparam logic signed [Z_W-1:0]    NEG_HALF_PI_Z = Z_W'(-102944);
    localparam logic signed [ANGLE_W-1:0] PI_ANGLE     = ANGLE_W'(25736);
    localparam logic signed [ANGLE_W-1:0] NEG_PI_ANGLE = ANGLE_W'(-25736);

    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // r00 sits in the lowest bits, matching the input tdata layout.
    typedef struct packed {
        sample_t r12;
        sample_t r11;
        sample_t r22;
        sample_t r21;
        sample_t r20;
        sample_t r10;
        sample_t r00;
    } matrix_t;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] root;
        matrix_t          m;
    } sqrt_t;

    typedef struct packed {
        logic signed [CD_W-1:0] x;
        logic signed [CD_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } vec_t;

    typedef struct packed {
        vec_t [N_LANES-1:0] v;
        logic [N_LANES-1:0] zero;
        logic               sing;
    } cordic_t;

    // Test bit of square root cell k: 4^(SQRT_STAGES-1-k).
    function automatic logic [SUM_W-1:0] sqrt_bit(input logic [SQ_IDX_W-1:0] k);
        return SUM_W'(1) << (2 * (SQRT_STAGES - 1 - int'(k)));
    endfunction

    // atan(2^-i) in Q.16 radians, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
        logic signed [Z_W-1:0] a;
        case (i)
            5'd0:    a = Z_W'(51472);
            5'd1:    a = Z_W'(30386);
            5'd2:    a = Z_W'(16055);
            5'd3:    a = Z_W'(8150);
            5'd4:    a = Z_W'(4091);
            5'd5:    a = Z_W'(2047);
            5'd6:    a = Z_W'(1024);
            5'd7:    a = Z_W'(512);
            5'd8:    a = Z_W'(256);
            5'd9:    a = Z_W'(128);
            5'd10:   a = Z_W'(64);
            5'd11:   a = Z_W'(32);
            5'd12:   a = Z_W'(16);
            5'd13:   a = Z_W'(8);
            5'd14:   a = Z_W'(4);
            5'd15:   a = Z_W'(2);
            5'd16:   a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/rotation_matrix_to_euler_top.sv
// Top level of the ZYX Euler angle converter: squares, square root chain,
// branch selection, CORDIC chain and output register. Depends on rme_pkg,
// rme_sqrt_cell and rme_cordic_cell.
//
//   port group   direction  payload (lowest bit first)
//   s_axis_*     in         tdata: r00, r10, r20, r21, r22, r11, r12
//   m_axis_*     out        tdata: roll, pitch, yaw; tuser: singular
//   cfg_*        in         cfg_wdata: singular_threshold
//
// One item enters per cycle while no result waits at the output; each passes through
// two registers for the squares and their sum, 16 square root cells, one branch
// select register, 16 CORDIC cells and the output register.
// aresetn clears all valid flags and sets singular_threshold to 1.
// A waiting result freezes the whole chain, so s_axis_tready drops only while
// m_axis_tvalid is high and m_axis_tready is low.
module rotation_matrix_to_euler_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rme_pkg::THR_W-1:0]        cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // r00, r10, r20, r21, r22, r11, r12
    input  logic [rme_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // roll, pitch, yaw
    output logic [rme_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // singular
    output logic                             m_axis_tuser
);
    import rme_pkg::*;

    logic                    en;
    logic [THR_W-1:0]        thr_reg;

    matrix_t                 in_m;
    logic [SAMPLE_WIDTH-1:0] abs_r00;
    logic [SAMPLE_WIDTH-1:0] abs_r10;

    logic                    s1_valid_reg;
    logic [SUM_W-1:0]        s1_sq0_reg;
    logic [SUM_W-1:0]        s1_sq1_reg;
    matrix_t                 s1_m_reg;

    logic                    s2_valid_reg;
    sqrt_t                   s2_d_reg;

    logic                    sq_valid [0:SQRT_STAGES];
    sqrt_t                   sq_d     [0:SQRT_STAGES];

    logic [SY_W-1:0]         sy;
    matrix_t                 sq_m;
    logic                    sing;
    cordic_t                 pre_next;
    cordic_t                 pre_reg;
    logic                    pre_valid_reg;

    logic                    cd_valid [0:CORDIC_STAGES];
    cordic_t                 cd_d     [0:CORDIC_STAGES];

    logic [ANGLE_W-1:0]      roll_w;
    logic [ANGLE_W-1:0]      pitch_w;
    logic [ANGLE_W-1:0]      yaw_w;
    logic                    m_valid_reg;
    logic [OUT_TDATA_W-1:0]  m_data_reg;
    logic                    m_user_reg;

    // Scale to Q.30 and turn a vector in the left half plane by +/- pi/2.
    function automatic vec_t vec_init(input logic signed [OPND_W-1:0] y0,
                                      input logic signed [OPND_W-1:0] x0);
        vec_t                   v;
        logic signed [CD_W-1:0] xw;
        logic signed [CD_W-1:0] yw;
        xw = CD_W'(x0) <<< GUARD_SHIFT;
        yw = CD_W'(y0) <<< GUARD_SHIFT;
        if (x0[OPND_W-1]) begin
            if (!y0[OPND_W-1]) begin
                v.x = yw;
                v.y = -xw;
                v.z = HALF_PI_Z;
            end else begin
                v.x = -yw;
                v.y = xw;
                v.z = NEG_HALF_PI_Z;
            end
        end else begin
            v.x = xw;
            v.y = yw;
            v.z = '0;
        end
        return v;
    endfunction

    // Round Q.16 to Q3.13 and clamp to +/- pi; atan2(0, 0) is zero.
    function automatic logic [ANGLE_W-1:0] angle_out(input logic signed [Z_W-1:0] z,
                                                     input logic zero);
        logic signed [Z_W:0]   zr;
        logic signed [Z_W-3:0] zs;
        logic [ANGLE_W-1:0]    a;
        zr = {z[Z_W-1], z} + (Z_W+1)'(4);
        zs = zr[Z_W:3];
        if (zero) begin
            a = '0;
        end else if (zs > PI_ANGLE) begin
            a = PI_ANGLE;
        end else if (zs < NEG_PI_ANGLE) begin
            a = NEG_PI_ANGLE;
        end else begin
            a = zs[ANGLE_W-1:0];
        end
        return a;
    endfunction

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // Squares of |r00| and |r10|, then their sum.
    always_comb begin
        in_m    = matrix_t'(s_axis_tdata[N_IN*SAMPLE_WIDTH-1:0]);
        abs_r00 = in_m.r00[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_m.r00)
                                           : SAMPLE_WIDTH'(in_m.r00);
        abs_r10 = in_m.r10[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_m.r10)
                                           : SAMPLE_WIDTH'(in_m.r10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            pre_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= s_axis_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            pre_valid_reg <= sq_valid[SQRT_STAGES];
            m_valid_reg   <= cd_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sq0_reg    <= SUM_W'(abs_r00) * SUM_W'(abs_r00);
            s1_sq1_reg    <= SUM_W'(abs_r10) * SUM_W'(abs_r10);
            s1_m_reg      <= in_m;
            s2_d_reg.rem  <= s1_sq0_reg + s1_sq1_reg;
            s2_d_reg.root <= '0;
            s2_d_reg.m    <= s1_m_reg;
            pre_reg       <= pre_next;
            m_data_reg    <= {yaw_w, pitch_w, roll_w};
            m_user_reg    <= cd_d[CORDIC_STAGES].sing;
        end
    end

    assign sq_valid[0] = s2_valid_reg;
    assign sq_d[0]     = s2_d_reg;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        rme_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_idx (SQ_IDX_W'(k)),
            .in_valid  (sq_valid[k]),
            .in_d      (sq_d[k]),
            .out_valid (sq_valid[k+1]),
            .out_d     (sq_d[k+1])
        );
    end

    // Branch select and CORDIC start vectors.
    always_comb begin
        sy   = sq_d[SQRT_STAGES].root[SY_W-1:0];
        sq_m = sq_d[SQRT_STAGES].m;
        sing = {{THR_W{1'b0}}, sy} < {{SY_W{1'b0}}, thr_reg};

        pre_next.sing = sing;
        if (sing) begin
            pre_next.v[LANE_ROLL] = vec_init(-OPND_W'(sq_m.r12), OPND_W'(sq_m.r11));
            pre_next.zero[LANE_ROLL] = (sq_m.r12 == '0) && (sq_m.r11 == '0);
        end else begin
            pre_next.v[LANE_ROLL] = vec_init(OPND_W'(sq_m.r21), OPND_W'(sq_m.r22));
            pre_next.zero[LANE_ROLL] = (sq_m.r21 == '0) && (sq_m.r22 == '0);
        end
        pre_next.v[LANE_PITCH]    = vec_init(-OPND_W'(sq_m.r20), {1'b0, sy});
        pre_next.zero[LANE_PITCH] = (sq_m.r20 == '0) && (sy == '0);
        pre_next.v[LANE_YAW]      = vec_init(OPND_W'(sq_m.r10), OPND_W'(sq_m.r00));
        pre_next.zero[LANE_YAW]   = (sq_m.r10 == '0) && (sq_m.r00 == '0);
    end

    assign cd_valid[0] = pre_valid_reg;
    assign cd_d[0]     = pre_reg;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        rme_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_idx (CD_IDX_W'(k)),
            .in_valid  (cd_valid[k]),
            .in_d      (cd_d[k]),
            .out_valid (cd_valid[k+1]),
            .out_d     (cd_d[k+1])
        );
    end

    always_comb begin
        roll_w  = angle_out(cd_d[CORDIC_STAGES].v[LANE_ROLL].z,
                            cd_d[CORDIC_STAGES].zero[LANE_ROLL]);
        pitch_w = angle_out(cd_d[CORDIC_STAGES].v[LANE_PITCH].z,
                            cd_d[CORDIC_STAGES].zero[LANE_PITCH]);
        // Yaw is forced to zero in gimbal lock.
        yaw_w   = angle_out(cd_d[CORDIC_STAGES].v[LANE_YAW].z,
                            cd_d[CORDIC_STAGES].zero[LANE_YAW] ||
                            cd_d[CORDIC_STAGES].sing);
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

### hw/rtl/rme_sqrt_cell.sv
// One cell of the integer square root chain: settles one result bit per item.
// Depends on rme_pkg.
module rme_sqrt_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [rme_pkg::SQ_IDX_W-1:0]  stage_idx,
    input  logic                          in_valid,
    input  rme_pkg::sqrt_t                in_d,
    output logic                          out_valid,
    output rme_pkg::sqrt_t                out_d
);
    import rme_pkg::*;

    logic [SUM_W-1:0] bit_w;
    logic [SUM_W:0]   trial;
    logic             take;
    sqrt_t            d_next;
    sqrt_t            d_reg;
    logic             valid_reg;

    always_comb begin
        bit_w  = sqrt_bit(stage_idx);
        trial  = {1'b0, in_d.root} + {1'b0, bit_w};
        take   = {1'b0, in_d.rem} >= trial;
        d_next = in_d;
        if (take) begin
            d_next.rem  = in_d.rem - trial[SUM_W-1:0];
            d_next.root = (in_d.root >> 1) + bit_w;
        end else begin
            d_next.root = in_d.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;

endmodule

### hw/rtl/rme_cordic_cell.sv
// One CORDIC vectoring stage applied to the roll, pitch and yaw vectors side
// by side. Depends on rme_pkg.
module rme_cordic_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [rme_pkg::CD_IDX_W-1:0]  stage_idx,
    input  logic                          in_valid,
    input  rme_pkg::cordic_t              in_d,
    output logic                          out_valid,
    output rme_pkg::cordic_t              out_d
);
    import rme_pkg::*;

    cordic_t               d_next;
    cordic_t               d_reg;
    logic                  valid_reg;
    logic signed [Z_W-1:0] step_angle;

    always_comb begin
        step_angle = atan_q16(ATAN_IDX_W'(stage_idx));
        d_next     = in_d;
        for (int l = 0; l < N_LANES; l++) begin
            // Rotate toward the x axis; the sign of y picks the direction.
            if (!in_d.v[l].y[CD_W-1]) begin
                d_next.v[l].x = in_d.v[l].x + (in_d.v[l].y >>> stage_idx);
                d_next.v[l].y = in_d.v[l].y - (in_d.v[l].x >>> stage_idx);
                d_next.v[l].z = in_d.v[l].z + step_angle;
            end else begin
                d_next.v[l].x = in_d.v[l].x - (in_d.v[l].y >>> stage_idx);
                d_next.v[l].y = in_d.v[l].y + (in_d.v[l].x >>> stage_idx);
                d_next.v[l].z = in_d.v[l].z - step_angle;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;

endmodule

### hw/rtl/rme_checker.sv
// Port-level checks for rotation_matrix_to_euler_top and the bind that
// attaches them. Depends on rme_pkg and the top level.
module rme_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rme_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);
    import rme_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // The input side only waits on a result that is held at the output.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    // Gimbal lock reports a zero yaw.
    a_sing_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3*ANGLE_W-1:2*ANGLE_W] == '0)
        else $error("yaw not zero in gimbal lock");

    // Roll stays within +/- pi.
    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            $signed(m_axis_tdata[ANGLE_W-1:0]) <= PI_ANGLE &&
            $signed(m_axis_tdata[ANGLE_W-1:0]) >= NEG_PI_ANGLE)
        else $error("roll out of range");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind rotation_matrix_to_euler_top rme_checker u_rme_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
